// ===== rtl/core/packed_glyph_row_renderer_top_assert.svh =====
// Assertion macros for the packed glyph row renderer checker.
// Needs nothing else; included by the checker file only.
`ifndef PACKED_GLYPH_ROW_RENDERER_TOP_ASSERT_SVH
`define PACKED_GLYPH_ROW_RENDERER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PGR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pgr checker: same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define PGR_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pgr checker: next-cycle implication violated");

`endif

// ===== rtl/core/pgr_pkg.sv =====
// Shared constants, codes and beat types of the packed glyph row renderer.
// Depends on nothing; every other file of the block but the assertion macro header uses it.
`timescale 1ns / 1ps

package pgr_pkg;

  localparam int unsigned BITMAP_BYTES_DEF     = 8192;
  localparam int unsigned GLYPH_COUNT_DEF      = 128;
  localparam int unsigned MAX_GLYPH_WIDTH_DEF  = 32;
  localparam int unsigned MAX_GLYPH_HEIGHT_DEF = 48;

  // A draw never emits more rows than this.
  localparam int unsigned RESULT_LIMIT = 48;
  // Columns that appear in a row mask.
  localparam int unsigned MASK_W = 32;

  localparam logic [7:0] FIRST_CHAR_RST = 8'd32;
  localparam logic [7:0] BASELINE_RST   = 8'd29;

  typedef enum logic [1:0] {
    CMD_LOAD_BYTE  = 2'd0,
    CMD_LOAD_GLYPH = 2'd1,
    CMD_DRAW       = 2'd2
  } cmd_e;

  typedef enum logic [7:0] {
    CFG_FIRST_CHAR = 8'd0,
    CFG_BASELINE   = 8'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [12:0] address;
    logic [55:0] data;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  scale;
    logic [15:0] pixel_color;
    logic [7:0]  char_code;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] row_x;
    logic signed [15:0] row_y;
    logic [31:0]        row_mask;
    logic [7:0]         cell_size;
    logic [15:0]        row_color;
    logic [15:0]        advance;
    logic               last;
  } res_beat_t;

  typedef struct packed {
    logic [7:0] index;
    logic [7:0] value;
  } cfg_beat_t;

  // Control of the bitmap read pointer.
  typedef struct packed {
    logic load;
    logic step;
  } fetch_ctl_t;

endpackage

// ===== rtl/core/pgr_if.sv =====
// Valid/ready channel interfaces of the packed glyph row renderer.
// Depends on pgr_pkg for the beat types.
`timescale 1ns / 1ps

interface pgr_in_if;
  logic              valid;
  logic              ready;
  pgr_pkg::in_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface pgr_res_if;
  logic               valid;
  logic               ready;
  pgr_pkg::res_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface pgr_cfg_if;
  logic               valid;
  logic               ready;
  pgr_pkg::cfg_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/pgr_bitmap_mem.sv =====
// Font bitmap byte store with its wrapping stream read pointer.
// Depends on pgr_pkg for the pointer control struct.
`timescale 1ns / 1ps

module pgr_bitmap_mem #(
  parameter int unsigned BITMAP_BYTES = pgr_pkg::BITMAP_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [$clog2(BITMAP_BYTES)-1:0] wr_idx_i,
  input  logic [7:0]                      wr_data_i,
  input  pgr_pkg::fetch_ctl_t             ctl_i,
  input  logic [15:0]                     start_raw_i,
  input  logic [$clog2(BITMAP_BYTES)-1:0] start_idx_i,
  output logic [7:0]                      rd_data_o
);

  localparam int unsigned BA = $clog2(BITMAP_BYTES);
  localparam logic [BA-1:0] IDX_MAX = BA'(BITMAP_BYTES - 1);

  logic [7:0]    mem [BITMAP_BYTES];
  logic [7:0]    rd_q;
  logic [15:0]   ptr_raw_q, ptr_raw_d;
  logic [BA-1:0] ptr_idx_q, ptr_idx_d;

  // The raw address wraps at 2^16, and the store index follows it modulo the depth.
  always_comb begin
    if (ptr_raw_q == 16'hFFFF) begin
      ptr_raw_d = '0;
      ptr_idx_d = '0;
    end else begin
      ptr_raw_d = ptr_raw_q + 16'd1;
      ptr_idx_d = (ptr_idx_q == IDX_MAX) ? '0 : ptr_idx_q + BA'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      ptr_raw_q <= start_raw_i;
      ptr_idx_q <= start_idx_i;
    end else if (ctl_i.step) begin
      ptr_raw_q <= ptr_raw_d;
      ptr_idx_q <= ptr_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    if (ctl_i.step) begin
      rd_q <= mem[ptr_idx_q];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== rtl/core/pgr_glyph_tab.sv =====
// Glyph record table: clamps records on load and stores the wrapped start index.
// Depends on pgr_pkg for default sizes and the row limit.
`timescale 1ns / 1ps

module pgr_glyph_tab #(
  parameter int unsigned GLYPH_COUNT      = pgr_pkg::GLYPH_COUNT_DEF,
  parameter int unsigned BITMAP_BYTES     = pgr_pkg::BITMAP_BYTES_DEF,
  parameter int unsigned MAX_GLYPH_WIDTH  = pgr_pkg::MAX_GLYPH_WIDTH_DEF,
  parameter int unsigned MAX_GLYPH_HEIGHT = pgr_pkg::MAX_GLYPH_HEIGHT_DEF,
  localparam int unsigned GA   = $clog2(GLYPH_COUNT),
  localparam int unsigned BA   = $clog2(BITMAP_BYTES),
  localparam int unsigned WW   = $clog2(MAX_GLYPH_WIDTH + 1),
  localparam int unsigned HLIM = (MAX_GLYPH_HEIGHT < pgr_pkg::RESULT_LIMIT) ?
                                 MAX_GLYPH_HEIGHT : pgr_pkg::RESULT_LIMIT,
  localparam int unsigned HW   = $clog2(HLIM + 1)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [GA-1:0] wr_idx_i,
  input  logic [55:0]   wr_data_i,
  input  logic          rd_en_i,
  input  logic [GA-1:0] rd_idx_i,
  output logic [15:0]   g_offset_o,
  output logic [BA-1:0] g_start_o,
  output logic [WW-1:0] g_width_o,
  output logic [HW-1:0] g_height_o,
  output logic [7:0]    g_adv_o,
  output logic [7:0]    g_xoff_o,
  output logic [7:0]    g_yoff_o
);

  localparam int unsigned RW = 16 + BA + WW + HW + 24;
  localparam logic [24:0] NB = 25'(BITMAP_BYTES);

  logic [RW-1:0] mem [GLYPH_COUNT];
  logic [RW-1:0] rd_q;
  logic [RW-1:0] wrec;
  logic [7:0]    w8, h8;
  logic [WW-1:0] w_cl;
  logic [HW-1:0] h_cl;
  logic [24:0]   rem;

  // Offset modulo the store depth: the quotient stays below 256 since the
  // depth is at least 256, so eight restoring steps suffice.
  always_comb begin
    rem = 25'(wr_data_i[15:0]);
    for (int k = 7; k >= 0; k--) begin
      if (rem >= (NB << k)) begin
        rem = rem - (NB << k);
      end
    end
  end

  always_comb begin
    w8   = wr_data_i[23:16];
    h8   = wr_data_i[31:24];
    w_cl = (w8 > 8'(MAX_GLYPH_WIDTH)) ? WW'(MAX_GLYPH_WIDTH) : WW'(w8);
    h_cl = (h8 > 8'(HLIM)) ? HW'(HLIM) : HW'(h8);
    wrec = {wr_data_i[15:0], BA'(rem), w_cl, h_cl,
            wr_data_i[39:32], wr_data_i[47:40], wr_data_i[55:48]};
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_idx_i] <= wrec;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_idx_i];
    end
  end

  assign {g_offset_o, g_start_o, g_width_o, g_height_o, g_adv_o, g_xoff_o, g_yoff_o} = rd_q;

endmodule

// ===== rtl/core/pgr_row_seq.sv =====
// Draw sequencer: glyph lookup, coordinate math, bit stream to row masks.
// Depends on pgr_pkg; drives the glyph table read and the bitmap pointer.
`timescale 1ns / 1ps

module pgr_row_seq #(
  parameter int unsigned GLYPH_COUNT      = pgr_pkg::GLYPH_COUNT_DEF,
  parameter int unsigned MAX_GLYPH_WIDTH  = pgr_pkg::MAX_GLYPH_WIDTH_DEF,
  parameter int unsigned MAX_GLYPH_HEIGHT = pgr_pkg::MAX_GLYPH_HEIGHT_DEF,
  localparam int unsigned GA   = $clog2(GLYPH_COUNT),
  localparam int unsigned WW   = $clog2(MAX_GLYPH_WIDTH + 1),
  localparam int unsigned HLIM = (MAX_GLYPH_HEIGHT < pgr_pkg::RESULT_LIMIT) ?
                                 MAX_GLYPH_HEIGHT : pgr_pkg::RESULT_LIMIT,
  localparam int unsigned HW   = $clog2(HLIM + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  pgr_pkg::in_beat_t   in_beat_i,
  output logic                in_ready_o,
  input  logic [7:0]          first_char_i,
  input  logic [7:0]          baseline_i,
  output logic                gt_rd_en_o,
  output logic [GA-1:0]       gt_rd_idx_o,
  input  logic [WW-1:0]       g_width_i,
  input  logic [HW-1:0]       g_height_i,
  input  logic [7:0]          g_adv_i,
  input  logic [7:0]          g_xoff_i,
  input  logic [7:0]          g_yoff_i,
  output pgr_pkg::fetch_ctl_t fetch_o,
  input  logic [7:0]          byte_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output pgr_pkg::res_beat_t  res_beat_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MISS  = 3'd1;
  localparam logic [2:0] ST_GLYPH = 3'd2;
  localparam logic [2:0] ST_PREP  = 3'd3;
  localparam logic [2:0] ST_FILL  = 3'd4;
  localparam logic [2:0] ST_RUN   = 3'd5;

  logic [2:0]  state_q, state_d;
  logic        accept, is_draw, in_range, out_free;
  logic [7:0]  idx;

  logic [15:0] px_q, py_q, color_q, adv_q, xprod_q, yprod_q, rx_q, ry_q;
  logic [7:0]  scl_q, byte_q;
  logic [WW-1:0] width_q, col_q, rem_row, col_n;
  logic [HW-1:0] last_row_q, row_q;
  logic [2:0]  bit_q;
  logic [31:0] mask_q, placed;

  logic signed [9:0]  ysum;
  logic signed [16:0] xmul;
  logic signed [18:0] ymul;
  logic [15:0]        admul;

  logic [3:0]  rem_byte, k, bit_n;
  logic [7:0]  aligned, rev, kmask, newbits;
  logic [39:0] wide;
  logic        row_done, run_go, emit, is_last;
  pgr_pkg::res_beat_t emit_beat, res_q;
  logic        res_valid_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign is_draw     = (in_beat_i.command == pgr_pkg::CMD_DRAW);
  assign idx         = in_beat_i.char_code - first_char_i;
  assign in_range    = ({1'b0, idx} < 9'(GLYPH_COUNT));
  assign gt_rd_en_o  = accept && is_draw && in_range;
  assign gt_rd_idx_o = GA'(idx);
  assign out_free    = !res_valid_q || res_ready_i;

  // Products of the fetched record; registered before the additions.
  always_comb begin
    ysum  = $signed({2'b00, baseline_i}) + $signed({{2{g_yoff_i[7]}}, g_yoff_i});
    xmul  = $signed(g_xoff_i) * $signed({1'b0, scl_q});
    ymul  = ysum * $signed({1'b0, scl_q});
    admul = g_adv_i * scl_q;
  end

  // Bits of the current byte that go into the current row, MSB first.
  always_comb begin
    rem_row  = width_q - col_q;
    rem_byte = 4'd8 - {1'b0, bit_q};
    k        = (rem_row < WW'(rem_byte)) ? 4'(rem_row) : rem_byte;
    aligned  = byte_q << bit_q;
    for (int j = 0; j < 8; j++) begin
      rev[j] = aligned[7-j];
    end
    kmask    = 8'((9'd1 << k) - 9'd1);
    newbits  = rev & kmask;
    wide     = 40'(newbits) << 5'(col_q);
    placed   = (8'(col_q) < 8'(pgr_pkg::MASK_W)) ? wide[31:0] : '0;
    col_n    = col_q + WW'(k);
    bit_n    = {1'b0, bit_q} + k;
    row_done = (col_n == width_q);
    is_last  = (row_q == last_row_q);
  end

  always_comb begin
    state_d   = state_q;
    emit      = 1'b0;
    run_go    = 1'b0;
    fetch_o   = '0;
    emit_beat = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && is_draw) begin
          state_d = in_range ? ST_GLYPH : ST_MISS;
        end
      end
      ST_MISS: begin
        if (out_free) begin
          emit                = 1'b1;
          emit_beat.row_x     = $signed(px_q);
          emit_beat.row_y     = $signed(py_q);
          emit_beat.cell_size = scl_q;
          emit_beat.row_color = color_q;
          emit_beat.last      = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      ST_GLYPH: begin
        fetch_o.load = 1'b1;
        state_d      = ST_PREP;
      end
      ST_PREP: begin
        fetch_o.step = 1'b1;
        state_d      = ST_FILL;
      end
      ST_FILL: begin
        fetch_o.step = 1'b1;
        state_d      = ST_RUN;
      end
      ST_RUN: begin
        run_go       = !row_done || out_free;
        fetch_o.step = run_go && (bit_n == 4'd8);
        if (run_go && row_done) begin
          emit                = 1'b1;
          emit_beat.row_x     = $signed(rx_q);
          emit_beat.row_y     = $signed(ry_q);
          emit_beat.row_mask  = mask_q | placed;
          emit_beat.cell_size = scl_q;
          emit_beat.row_color = color_q;
          emit_beat.advance   = is_last ? adv_q : '0;
          emit_beat.last      = is_last;
          if (is_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_draw) begin
      px_q    <= in_beat_i.pos_x;
      py_q    <= in_beat_i.pos_y;
      scl_q   <= in_beat_i.scale;
      color_q <= in_beat_i.pixel_color;
    end
    if (state_q == ST_GLYPH) begin
      // A glyph of height zero gives one empty row.
      width_q    <= (g_height_i == '0) ? '0 : g_width_i;
      last_row_q <= (g_height_i == '0) ? '0 : g_height_i - HW'(1);
      adv_q      <= admul;
      xprod_q    <= xmul[15:0];
      yprod_q    <= ymul[15:0];
    end
    if (state_q == ST_PREP) begin
      rx_q <= px_q + xprod_q;
      ry_q <= py_q + yprod_q;
    end
    if (state_q == ST_FILL) begin
      byte_q <= byte_i;
      bit_q  <= '0;
      col_q  <= '0;
      row_q  <= '0;
      mask_q <= '0;
    end
    if (run_go) begin
      if (bit_n == 4'd8) begin
        byte_q <= byte_i;
        bit_q  <= '0;
      end else begin
        bit_q <= bit_n[2:0];
      end
      if (row_done) begin
        col_q  <= '0;
        mask_q <= '0;
        row_q  <= row_q + HW'(1);
        ry_q   <= ry_q + {8'd0, scl_q};
      end else begin
        col_q  <= col_n;
        mask_q <= mask_q | placed;
      end
    end
    if (emit) begin
      res_q <= emit_beat;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_beat_o  = res_q;

endmodule

// ===== rtl/core/packed_glyph_row_renderer_top.sv =====
// Packed glyph row renderer, top level: configuration registers, load decode,
// and the glyph table, bitmap store and draw sequencer. Depends on pgr_pkg, pgr_if.
`timescale 1ns / 1ps

// The block renders one character of a packed bitmap font into per-row column
// masks. Load beats (command 0 and 1) fill the bitmap byte store and the glyph
// record table; a load whose address lies beyond the store is dropped. Neither
// store is cleared at reset, so every entry a draw touches must be loaded
// first. A draw beat (command 2) is followed by one result beat per glyph row,
// MSB-first bits read as one continuous stream; the final beat has last set
// and carries the advance. Input is not taken while a draw is in progress.
// After the cycle that accepts it, a draw passes through the GLYPH, PREP and
// FILL states for lookup and coordinate setup, then builds each row from the
// bitmap store, which has a single byte-wide read port that the stream walks
// byte by byte. A character outside the glyph table yields one empty beat at
// the origin. Coordinates wrap modulo 2^16. Result beats leave through an
// output register, so the next beat is built while the previous one waits,
// and backpressure simply stalls the stream.

module packed_glyph_row_renderer_top #(
  parameter int unsigned BITMAP_BYTES     = pgr_pkg::BITMAP_BYTES_DEF,
  parameter int unsigned GLYPH_COUNT      = pgr_pkg::GLYPH_COUNT_DEF,
  parameter int unsigned MAX_GLYPH_WIDTH  = pgr_pkg::MAX_GLYPH_WIDTH_DEF,
  parameter int unsigned MAX_GLYPH_HEIGHT = pgr_pkg::MAX_GLYPH_HEIGHT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pgr_in_if.sink    in_i,
  pgr_res_if.source res_o,
  pgr_cfg_if.sink   cfg_i
);

  localparam int unsigned GA   = $clog2(GLYPH_COUNT);
  localparam int unsigned BA   = $clog2(BITMAP_BYTES);
  localparam int unsigned WW   = $clog2(MAX_GLYPH_WIDTH + 1);
  localparam int unsigned HLIM = (MAX_GLYPH_HEIGHT < pgr_pkg::RESULT_LIMIT) ?
                                 MAX_GLYPH_HEIGHT : pgr_pkg::RESULT_LIMIT;
  localparam int unsigned HW   = $clog2(HLIM + 1);

  // Configuration registers. The port is always ready; writes to indexes
  // beyond the two registers are accepted and ignored.
  logic [7:0] first_char_q, baseline_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_char_q <= pgr_pkg::FIRST_CHAR_RST;
      baseline_q   <= pgr_pkg::BASELINE_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.payload.index)
        pgr_pkg::CFG_FIRST_CHAR: first_char_q <= cfg_i.payload.value;
        pgr_pkg::CFG_BASELINE:   baseline_q   <= cfg_i.payload.value;
        default: begin
        end
      endcase
    end
  end

  // Load decode. Loads complete at the accepting edge; the sequencer only
  // accepts in its idle state, so a store is never written and streamed at
  // the same time and needs no forwarding.
  logic          in_ready, in_acc, bmp_we, gt_we;
  logic          gt_rd_en;
  logic [GA-1:0] gt_rd_idx;

  assign in_acc = in_i.valid && in_ready;
  assign bmp_we = in_acc && (in_i.payload.command == pgr_pkg::CMD_LOAD_BYTE) &&
                  ({4'b0000, in_i.payload.address} < 17'(BITMAP_BYTES));
  assign gt_we  = in_acc && (in_i.payload.command == pgr_pkg::CMD_LOAD_GLYPH) &&
                  ({1'b0, in_i.payload.address} < 14'(GLYPH_COUNT));
  assign in_i.ready = in_ready;

  logic [15:0]         g_offset;
  logic [BA-1:0]       g_start;
  logic [WW-1:0]       g_width;
  logic [HW-1:0]       g_height;
  logic [7:0]          g_adv, g_xoff, g_yoff, bmp_byte;
  pgr_pkg::fetch_ctl_t fetch;

  pgr_glyph_tab #(
    .GLYPH_COUNT     (GLYPH_COUNT),
    .BITMAP_BYTES    (BITMAP_BYTES),
    .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH),
    .MAX_GLYPH_HEIGHT(MAX_GLYPH_HEIGHT)
  ) u_glyph_tab (
    .clk_i     (clk_i),
    .we_i      (gt_we),
    .wr_idx_i  (GA'(in_i.payload.address)),
    .wr_data_i (in_i.payload.data),
    .rd_en_i   (gt_rd_en),
    .rd_idx_i  (gt_rd_idx),
    .g_offset_o(g_offset),
    .g_start_o (g_start),
    .g_width_o (g_width),
    .g_height_o(g_height),
    .g_adv_o   (g_adv),
    .g_xoff_o  (g_xoff),
    .g_yoff_o  (g_yoff)
  );

  pgr_bitmap_mem #(
    .BITMAP_BYTES(BITMAP_BYTES)
  ) u_bitmap_mem (
    .clk_i      (clk_i),
    .we_i       (bmp_we),
    .wr_idx_i   (BA'(in_i.payload.address)),
    .wr_data_i  (in_i.payload.data[7:0]),
    .ctl_i      (fetch),
    .start_raw_i(g_offset),
    .start_idx_i(g_start),
    .rd_data_o  (bmp_byte)
  );

  pgr_row_seq #(
    .GLYPH_COUNT     (GLYPH_COUNT),
    .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH),
    .MAX_GLYPH_HEIGHT(MAX_GLYPH_HEIGHT)
  ) u_row_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_beat_i   (in_i.payload),
    .in_ready_o  (in_ready),
    .first_char_i(first_char_q),
    .baseline_i  (baseline_q),
    .gt_rd_en_o  (gt_rd_en),
    .gt_rd_idx_o (gt_rd_idx),
    .g_width_i   (g_width),
    .g_height_i  (g_height),
    .g_adv_i     (g_adv),
    .g_xoff_i    (g_xoff),
    .g_yoff_i    (g_yoff),
    .fetch_o     (fetch),
    .byte_i      (bmp_byte),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .res_beat_o  (res_o.payload)
  );

endmodule

// ===== rtl/core/pgr_checker.sv =====
// Port-level checker of the packed glyph row renderer, bound to its top level.
// Depends on pgr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "packed_glyph_row_renderer_top_assert.svh"

module pgr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic [1:0]         in_cmd_i,
  input logic               res_valid_i,
  input logic               res_ready_i,
  input pgr_pkg::res_beat_t res_beat_i
);

  logic draw_acc, res_stall;

  assign draw_acc  = in_valid_i && in_ready_i && (in_cmd_i == pgr_pkg::CMD_DRAW);
  assign res_stall = res_valid_i && !res_ready_i;

  // A draw always blocks the input for at least the following cycle.
  `PGR_ASSERT_NXT(a_draw_blocks_input, clk_i, rst_ni, draw_acc, !in_ready_i)
  // Only the final row of a draw carries an advance.
  `PGR_ASSERT_IMP(a_adv_on_last, clk_i, rst_ni, res_valid_i && !res_beat_i.last,
                  res_beat_i.advance == 16'd0)
  // A stalled result beat stays offered and unchanged.
  `PGR_ASSERT_NXT(a_res_hold, clk_i, rst_ni, res_stall, res_valid_i)
  `PGR_ASSERT_NXT(a_res_stable, clk_i, rst_ni, res_stall, $stable(res_beat_i))

endmodule

bind packed_glyph_row_renderer_top pgr_checker u_pgr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .in_cmd_i   (in_i.payload.command),
  .res_valid_i(res_o.valid),
  .res_ready_i(res_o.ready),
  .res_beat_i (res_o.payload)
);

// ===== tb/sv/packed_glyph_row_renderer_checker.sv =====
// Scoreboard for the packed glyph row renderer: keeps its own copy of the font
// stores and registers, predicts the row beats of each draw and checks them.
// Depends on pgr_pkg and the channel interfaces in pgr_if.
`timescale 1ns / 1ps

module packed_glyph_row_renderer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  pgr_in_if           in_mon,
  pgr_res_if          res_mon,
  pgr_cfg_if          cfg_mon,
  output int unsigned fail_count_o,
  output int unsigned rows_pending_o
);
  import pgr_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [15:0]        offset;
    logic [7:0]         width;
    logic [7:0]         height;
    logic [7:0]         x_advance;
    logic signed [7:0]  x_offset;
    logic signed [7:0]  y_offset;
  } glyph_rec_t;

  glyph_rec_t  glyph_tbl [GLYPH_COUNT_DEF];
  logic [7:0]  font_bytes [BITMAP_BYTES_DEF];
  logic [7:0]  first_char_q;
  logic [7:0]  baseline_q;
  res_beat_t   expected_rows [$];
  res_beat_t   want_row;
  res_beat_t   got_row;
  glyph_rec_t  new_glyph;
  int unsigned failures;

  // Works out every row beat one draw produces and queues them in order.
  function automatic void predict_draw_rows(in_beat_t b);
    logic [7:0]  idx;
    glyph_rec_t  g;
    res_beat_t   row;
    int unsigned bitpos;
    int unsigned nrows;
    int unsigned r;
    int unsigned c;
    logic [15:0] byte_addr;
    logic [7:0]  byte_val;
    idx           = b.char_code - first_char_q;
    row.cell_size = b.scale;
    row.row_color = b.pixel_color;
    row.row_mask  = '0;
    row.advance   = '0;
    row.last      = 1'b1;
    if (idx >= GLYPH_COUNT_DEF) begin
      row.row_x = b.pos_x;
      row.row_y = b.pos_y;
      expected_rows.push_back(row);
      return;
    end
    g         = glyph_tbl[idx];
    row.row_x = 16'(int'(b.pos_x) + int'(g.x_offset) * int'(b.scale));
    nrows     = (g.height == 0) ? 1 : int'(g.height);
    bitpos    = 0;
    for (r = 0; r < nrows; r++) begin
      row.row_mask = '0;
      if (g.height != 0) begin
        for (c = 0; c < g.width; c++) begin
          byte_addr = g.offset + 16'(bitpos >> 3);
          byte_val  = font_bytes[byte_addr % BITMAP_BYTES_DEF];
          if (c < MASK_W && byte_val[7 - (bitpos % 8)]) row.row_mask[c] = 1'b1;
          bitpos++;
        end
      end
      row.row_y   = 16'(int'(b.pos_y)
                    + (int'(baseline_q) + int'(g.y_offset) + int'(r)) * int'(b.scale));
      row.last    = (r + 1 == nrows);
      row.advance = row.last ? 16'(int'(g.x_advance) * int'(b.scale)) : 16'h0000;
      expected_rows.push_back(row);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_char_q = FIRST_CHAR_RST;
      baseline_q   = BASELINE_RST;
      expected_rows.delete();
      failures     = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        got_row = res_mon.payload;
        if (expected_rows.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("%0t: row beat with nothing expected: x=%0d y=%0d mask=%h last=%0b",
                     $realtime, got_row.row_x, got_row.row_y, got_row.row_mask,
                     got_row.last);
        end else begin
          want_row = expected_rows.pop_front();
          if (want_row.row_x !== got_row.row_x || want_row.row_y !== got_row.row_y ||
              want_row.row_mask !== got_row.row_mask ||
              want_row.cell_size !== got_row.cell_size ||
              want_row.row_color !== got_row.row_color ||
              want_row.advance !== got_row.advance || want_row.last !== got_row.last) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
              $display("%0t: row beat differs", $realtime);
              $display("  expected x=%0d y=%0d mask=%h size=%0d color=%h adv=%0d last=%0b",
                       want_row.row_x, want_row.row_y, want_row.row_mask,
                       want_row.cell_size, want_row.row_color, want_row.advance,
                       want_row.last);
              $display("  actual   x=%0d y=%0d mask=%h size=%0d color=%h adv=%0d last=%0b",
                       got_row.row_x, got_row.row_y, got_row.row_mask,
                       got_row.cell_size, got_row.row_color, got_row.advance,
                       got_row.last);
            end
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.payload.index)
          CFG_FIRST_CHAR: first_char_q = cfg_mon.payload.value;
          CFG_BASELINE:   baseline_q   = cfg_mon.payload.value;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.payload.command)
          CMD_LOAD_BYTE: begin
            font_bytes[in_mon.payload.address] = in_mon.payload.data[7:0];
          end
          CMD_LOAD_GLYPH: begin
            if (in_mon.payload.address < GLYPH_COUNT_DEF) begin
              new_glyph.offset    = in_mon.payload.data[15:0];
              new_glyph.width     = (in_mon.payload.data[23:16] > MAX_GLYPH_WIDTH_DEF) ?
                                    8'(MAX_GLYPH_WIDTH_DEF) : in_mon.payload.data[23:16];
              new_glyph.height    = (in_mon.payload.data[31:24] > MAX_GLYPH_HEIGHT_DEF) ?
                                    8'(MAX_GLYPH_HEIGHT_DEF) : in_mon.payload.data[31:24];
              if (new_glyph.height > RESULT_LIMIT) new_glyph.height = 8'(RESULT_LIMIT);
              new_glyph.x_advance = in_mon.payload.data[39:32];
              new_glyph.x_offset  = in_mon.payload.data[47:40];
              new_glyph.y_offset  = in_mon.payload.data[55:48];
              glyph_tbl[in_mon.payload.address] = new_glyph;
            end
          end
          CMD_DRAW: predict_draw_rows(in_mon.payload);
          default: ;
        endcase
      end
    end
    fail_count_o   <= failures;
    rows_pending_o <= expected_rows.size();
  end

endmodule

// ===== tb/sv/tb_packed_glyph_row_renderer_top.sv =====
// Top of the packed glyph row renderer testbench: clock, reset, stimulus,
// result backpressure, watchdog and verdict. Depends on pgr_pkg, pgr_if,
// the renderer RTL and packed_glyph_row_renderer_checker.
`timescale 1ns / 1ps

module tb_packed_glyph_row_renderer_top;
  import pgr_pkg::*;

  // Command code 3 has no meaning; the block must drop it silently.
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;
  // Counted items over all random phases; ignored beats do not count. With
  // the preload and the directed part this makes about 320 beats in all.
  localparam int unsigned RANDOM_ITEMS   = 100;
  localparam int unsigned PHASES         = 4;
  // The first bytes of the bitmap store are filled before anything is drawn.
  localparam int unsigned PRELOAD_BYTES  = 200;
  // Length of the one long stall of the result side.
  localparam int unsigned HOLD_CYCLES    = 400;
  // Loads finish when they are accepted, so this covers any work left once rows are in.
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned SETTLE_CYCLES  = 40;
  // Longest legal quiet spell is the long stall; this limit lies above it.
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        calm         = 1'b0;
  logic        pressure_req = 1'b0;
  int unsigned fail_count;
  int unsigned rows_pending;

  pgr_in_if  in_ch ();
  pgr_res_if res_ch ();
  pgr_cfg_if cfg_ch ();

  // What the stimulus knows about the stores, so that a draw never touches an
  // entry that was never loaded. Glyph slots are indexed by table position.
  logic [7:0]  first_char_now = FIRST_CHAR_RST;
  bit          glyph_loaded [GLYPH_COUNT_DEF];
  logic [15:0] glyph_offset [GLYPH_COUNT_DEF];
  int unsigned glyph_bits   [GLYPH_COUNT_DEF];
  bit          byte_loaded  [BITMAP_BYTES_DEF];

  always #2 clk_i = ~clk_i;

  packed_glyph_row_renderer_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  packed_glyph_row_renderer_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon         (in_ch),
    .res_mon        (res_ch),
    .cfg_mon        (cfg_ch),
    .fail_count_o   (fail_count),
    .rows_pending_o (rows_pending)
  );

  // Every field random; callers overwrite the ones that matter, so the fields
  // a command does not use still see both values on every bit.
  function automatic in_beat_t random_beat();
    in_beat_t b;
    b.command     = 2'($urandom);
    b.address     = 13'($urandom);
    b.data        = 56'({$urandom(), $urandom()});
    b.pos_x       = 16'($urandom);
    b.pos_y       = 16'($urandom);
    b.scale       = 8'($urandom);
    b.pixel_color = 16'($urandom);
    b.char_code   = 8'($urandom);
    return b;
  endfunction

  function automatic logic [55:0] glyph_record(logic [15:0] offset, logic [7:0] w,
                                               logic [7:0] h, logic [7:0] adv,
                                               logic [7:0] xo, logic [7:0] yo);
    return {yo, xo, adv, h, w, offset};
  endfunction

  // Mostly small glyphs, so that few byte loads are needed; now and then a
  // wide or tall one, and offsets near the top of the 16-bit range to make
  // the stream address wrap.
  function automatic logic [55:0] random_glyph_record();
    logic [15:0] off;
    logic [7:0]  w;
    logic [7:0]  h;
    off = ($urandom_range(0, 7) == 0) ? (16'hFFF0 | 16'($urandom_range(0, 15)))
                                      : 16'($urandom);
    w   = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
    h   = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
    return glyph_record(off, w, h, 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  function automatic int unsigned glyph_bytes(int unsigned slot);
    return (glyph_bits[slot] + 7) / 8;
  endfunction

  // Byte k of a glyph's bit stream: the 16-bit offset wraps before the store
  // index drops its upper bits.
  function automatic logic [12:0] stream_byte_addr(int unsigned slot, int unsigned k);
    logic [15:0] a;
    a = glyph_offset[slot] + 16'(k);
    return a[12:0];
  endfunction

  function automatic bit glyph_safe(int unsigned slot);
    int unsigned k;
    if (!glyph_loaded[slot]) return 1'b0;
    for (k = 0; k < glyph_bytes(slot); k++)
      if (!byte_loaded[stream_byte_addr(slot, k)]) return 1'b0;
    return 1'b1;
  endfunction

  // Offers one beat and returns at the edge that accepts it. Valid is lowered
  // only for an idle burst that waits on the clock, so it gets one assignment per edge.
  task automatic send_beat(in_beat_t b);
    int unsigned w;
    int unsigned h;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    if (b.command == CMD_LOAD_BYTE) begin
      byte_loaded[b.address] = 1'b1;
    end else if (b.command == CMD_LOAD_GLYPH && b.address < GLYPH_COUNT_DEF) begin
      w = b.data[23:16];
      h = b.data[31:24];
      glyph_loaded[b.address] = 1'b1;
      glyph_offset[b.address] = b.data[15:0];
      glyph_bits[b.address]   = ((w > MAX_GLYPH_WIDTH_DEF) ? MAX_GLYPH_WIDTH_DEF : w) *
                                ((h > MAX_GLYPH_HEIGHT_DEF) ? MAX_GLYPH_HEIGHT_DEF : h);
    end
  endtask

  task automatic send_load(logic [1:0] cmd, logic [12:0] addr, logic [55:0] data);
    in_beat_t b;
    b         = random_beat();
    b.command = cmd;
    b.address = addr;
    b.data    = data;
    send_beat(b);
  endtask

  task automatic send_draw(logic [7:0] code, logic [15:0] px, logic [15:0] py,
                           logic [7:0] scl, logic [15:0] color);
    in_beat_t b;
    b             = random_beat();
    b.command     = CMD_DRAW;
    b.char_code   = code;
    b.pos_x       = px;
    b.pos_y       = py;
    b.scale       = scl;
    b.pixel_color = color;
    send_beat(b);
  endtask

  // Small scales keep the coordinates readable; a full-range one now and then.
  task automatic random_draw(logic [7:0] code);
    logic [7:0] scl;
    scl = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(1, 4));
    send_draw(code, 16'($urandom), 16'($urandom), scl, 16'($urandom));
  endtask

  // Fresh random content for every byte a glyph's stream touches.
  task automatic load_glyph_bytes(int unsigned slot);
    int unsigned k;
    for (k = 0; k < glyph_bytes(slot); k++)
      send_load(CMD_LOAD_BYTE, stream_byte_addr(slot, k), 56'({$urandom(), $urandom()}));
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [7:0] val);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= '{index: idx, value: val};
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stops offering beats and waits until every predicted row has come back,
  // then lets the block finish any load still in flight.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (rows_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Most of the traffic is a complete glyph: its record, the bytes it reads
  // and a few draws of it. The rest is stray loads, ignored beats, draws of
  // characters outside the table and redraws of glyphs loaded earlier.
  task automatic random_phase(int unsigned items);
    int unsigned done;
    int unsigned pick;
    int unsigned slot;
    int unsigned n;
    int unsigned k;
    logic [7:0]  code;
    logic [7:0]  idx;
    done = 0;
    while (done < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        slot = $urandom_range(0, GLYPH_COUNT_DEF - 1);
        send_load(CMD_LOAD_GLYPH, 13'(slot), random_glyph_record());
        load_glyph_bytes(slot);
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) random_draw(first_char_now + 8'(slot));
        done += 1 + n + glyph_bytes(slot);
      end else if (pick < 70) begin
        // Any code at all, steered outside the table if its glyph is not ready.
        code = 8'($urandom);
        idx  = code - first_char_now;
        if (idx < GLYPH_COUNT_DEF && !glyph_safe(idx))
          code = first_char_now + 8'(GLYPH_COUNT_DEF)
                 + 8'($urandom_range(0, 255 - GLYPH_COUNT_DEF));
        random_draw(code);
        done++;
      end else if (pick < 78) begin
        slot = $urandom_range(0, GLYPH_COUNT_DEF - 1);
        if (glyph_safe(slot)) begin
          random_draw(first_char_now + 8'(slot));
          done++;
        end
      end else if (pick < 86) begin
        send_load(CMD_LOAD_BYTE, 13'($urandom), 56'({$urandom(), $urandom()}));
        done++;
      end else if (pick < 92) begin
        send_load(CMD_LOAD_GLYPH, 13'($urandom_range(GLYPH_COUNT_DEF, 13'h1FFF)),
                  random_glyph_record());
      end else if (pick < 96) begin
        send_load(CMD_UNUSED, 13'($urandom), 56'({$urandom(), $urandom()}));
      end else begin
        // A record whose bytes may not be loaded yet; it is not drawn until
        // a later sequence fills them.
        send_load(CMD_LOAD_GLYPH, 13'($urandom_range(0, GLYPH_COUNT_DEF - 1)),
                  random_glyph_record());
        done++;
      end
    end
  endtask

  // Result side. Ready drops in random bursts until the last phase, and once,
  // when asked, it stays low long enough for the block to fill and stall its
  // input while the stimulus keeps offering draws.
  initial begin : result_sink
    bit pressure_done;
    pressure_done = 1'b0;
    res_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (pressure_req && !pressure_done) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        pressure_done = 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        res_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // The run ends with a failure if no beat moves on any channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("packed_glyph_row_renderer_top: mismatch");
    $finish;
  end

  initial begin : stimulus
    int unsigned a;
    int unsigned phase;
    logic [7:0]  fc_val;
    logic [7:0]  bl_val;
    in_ch.valid    <= 1'b0;
    in_ch.payload  <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.payload <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the low end of the bitmap store so that the directed glyphs,
    // including the largest one, only read bytes that hold known data.
    for (a = 0; a < PRELOAD_BYTES; a++)
      send_load(CMD_LOAD_BYTE, 13'(a), 56'({$urandom(), $urandom()}));

    // Directed part, with the registers still at their reset values.
    // An unknown command is dropped.
    send_load(CMD_UNUSED, 13'h1FFF, {56{1'b1}});
    // Last byte of the store, every data bit set; the stream of glyph 1
    // starts here and wraps to byte zero.
    send_load(CMD_LOAD_BYTE, 13'h1FFF, {56{1'b1}});
    send_load(CMD_LOAD_BYTE, 13'h0000, 56'h00_0000_0000_0080);
    // Plain 8x2 glyph with negative offsets.
    send_load(CMD_LOAD_GLYPH, 13'd0, glyph_record(16'h0000, 8'd8, 8'd2, 8'd6, 8'hFF, 8'hF4));
    // Rows of 5 bits straddle byte borders; offset wraps at 2^16.
    send_load(CMD_LOAD_GLYPH, 13'd1, glyph_record(16'hFFFF, 8'd5, 8'd3, 8'hFF, 8'h7F, 8'h80));
    // Width and height far above the limits, clamped at load; the offset
    // aliases onto the preloaded bytes.
    send_load(CMD_LOAD_GLYPH, 13'd127,
              glyph_record(16'h4008, 8'hFF, 8'hFF, 8'h80, 8'h80, 8'h7F));
    // Zero height gives one empty row; zero width gives empty rows.
    send_load(CMD_LOAD_GLYPH, 13'd2, glyph_record(16'h1234, 8'd7, 8'd0, 8'd9, 8'h00, 8'h00));
    send_load(CMD_LOAD_GLYPH, 13'd3, glyph_record(16'h0000, 8'd0, 8'd4, 8'd3, 8'h01, 8'hFE));
    // Records addressed past the table are dropped.
    send_load(CMD_LOAD_GLYPH, 13'd128, {56{1'b1}});
    send_load(CMD_LOAD_GLYPH, 13'h1FFF, 56'h0);
    send_draw(first_char_now, 16'h0000, 16'h0000, 8'd1, 16'h0000);
    send_draw(first_char_now + 8'd1, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_draw(first_char_now + 8'd127, 16'h1234, 16'h8000, 8'd2, 16'hF800);
    send_draw(first_char_now + 8'd127, 16'h7FFF, 16'h7FFF, 8'hFF, 16'h07E0);
    send_draw(first_char_now + 8'd2, 16'h0100, 16'h0200, 8'd3, 16'h001F);
    // Zero scale collapses everything onto the origin.
    send_draw(first_char_now + 8'd3, 16'hABCD, 16'h5432, 8'd0, 16'h1234);
    send_draw(first_char_now, 16'h8000, 16'h0001, 8'd0, 16'hFFFF);
    // Characters whose glyph index lands beyond the table.
    send_draw(first_char_now - 8'd1, 16'h0010, 16'h0020, 8'd4, 16'h0F0F);
    send_draw(first_char_now + 8'd128, 16'hFFFF, 16'h0000, 8'd1, 16'hF0F0);
    send_draw(8'hFF, 16'h0000, 16'hFFFF, 8'hFF, 16'h0000);
    send_draw(8'h00, 16'h5555, 16'hAAAA, 8'd7, 16'hFFFF);

    // Random phases. Registers change only with the block drained; the
    // extremes come first, then random values. The long result stall falls
    // in the second phase and the last phase runs without any idling.
    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: begin
          fc_val = 8'h00;
          bl_val = 8'h00;
        end
        1: begin
          fc_val = 8'hFF;
          bl_val = 8'hFF;
        end
        default: begin
          fc_val = 8'($urandom);
          bl_val = 8'($urandom);
        end
      endcase
      write_reg(CFG_FIRST_CHAR, fc_val);
      write_reg(CFG_BASELINE, bl_val);
      first_char_now = fc_val;
      if (phase == 1) pressure_req <= 1'b1;
      if (phase == PHASES - 1) calm <= 1'b1;
      random_phase(RANDOM_ITEMS / PHASES);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && rows_pending == 0)
      $display("packed_glyph_row_renderer_top: match");
    else
      $display("packed_glyph_row_renderer_top: mismatch");
    $finish;
  end

endmodule
